>>> hw/rtl/grid_bond_crossing_check_defines.svh
// ---------------------------------------------------------------------------
// Grid bond crossing check assertion macros
// Shared property forms for the crossing check; they expect clk and arst_n
// in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef GRID_BOND_CROSSING_CHECK_DEFINES_SVH
`define GRID_BOND_CROSSING_CHECK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define GBCC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GBCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/gbcc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid bond crossing check package
// Edge mask width and grid size defaults for the crossing check.
// ---------------------------------------------------------------------------
package gbcc_pkg;

	// Width of the incoming edge mask; bonds beyond it count as closed
	localparam int EDGE_BITS = 22;

	// Default grid size
	localparam int GRID_COLUMNS_DEF = 5;
	localparam int GRID_ROWS_DEF    = 3;

	// Relaxation steps done in one pipeline stage
	localparam int RELAX_STEPS = 4;

	// Byte-padded stream widths
	localparam int IN_TDATA_W  = ((EDGE_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

endpackage

>>> hw/rtl/grid_bond_crossing_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Grid bond crossing check
// Decides whether the open bonds of one edge mask join the left column of a
// vertex grid to its right column. Reachability grows from the left column
// over a chain of relaxation stages.
//
//   channel | dir | tdata fields (lowest bit up)
//   --------+-----+-----------------------------
//   s_*     | in  | edge_mask[21:0], zero pad
//   m_*     | out | crossed[0], zero pad
//
// One request enters per cycle while no stall on m_tready backs up the pipe;
// a request passes the relaxation stages (RELAX_STEPS bond hops each), as many
// as cover the longest path of GRID_ROWS * GRID_COLUMNS - 1 hops, then the result
// register. arst_n clears all valid bits. A stall on m_tready holds the
// result and lets requests close up into empty stages behind it.
// ---------------------------------------------------------------------------
module grid_bond_crossing_check
	import gbcc_pkg::*;
#(
	parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
	parameter int GRID_ROWS    = GRID_ROWS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [21:0] edge_mask, rest zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // [0] crossed, rest zero
);

`include "grid_bond_crossing_check_defines.svh"

	localparam int NV       = GRID_ROWS * GRID_COLUMNS;
	localparam int NB_H     = GRID_ROWS * (GRID_COLUMNS - 1);
	localparam int NB_ALL   = NB_H + (GRID_ROWS - 1) * GRID_COLUMNS;
	localparam int NB_USE   = (NB_ALL < EDGE_BITS) ? NB_ALL : EDGE_BITS;
	localparam int NUM_STAGES = (NV - 1 + RELAX_STEPS - 1) / RELAX_STEPS;

	// Left column seeds reachability
	function automatic logic [NV-1:0] left_column();
		logic [NV-1:0] r;
		r = '0;
		for (int y = 0; y < GRID_ROWS; y++) begin
			r[y*GRID_COLUMNS] = 1'b1;
		end
		return r;
	endfunction

	// Grow the reached set by RELAX_STEPS hops over open bonds
	function automatic logic [NV-1:0] relax(input logic [NV-1:0] seen_i,
			input logic [NB_USE-1:0] mask_i);
		logic [NB_ALL+NB_USE-1:0] ext;
		logic [NB_ALL-1:0]        bnd;
		logic [NV-1:0]            cur;
		logic [NV-1:0]            nxt;
		int                       v;
		ext = {{NB_ALL{1'b0}}, mask_i};
		bnd = ext[NB_ALL-1:0];
		cur = seen_i;
		for (int k = 0; k < RELAX_STEPS; k++) begin
			nxt = cur;
			for (int y = 0; y < GRID_ROWS; y++) begin
				for (int x = 0; x < GRID_COLUMNS; x++) begin
					v = y * GRID_COLUMNS + x;
					if (x + 1 < GRID_COLUMNS && bnd[y*(GRID_COLUMNS-1)+x] && cur[v+1])
						nxt[v] = 1'b1;
					if (x > 0 && bnd[y*(GRID_COLUMNS-1)+x-1] && cur[v-1])
						nxt[v] = 1'b1;
					if (y + 1 < GRID_ROWS && bnd[NB_H+y*GRID_COLUMNS+x]
							&& cur[v+GRID_COLUMNS])
						nxt[v] = 1'b1;
					if (y > 0 && bnd[NB_H+(y-1)*GRID_COLUMNS+x] && cur[v-GRID_COLUMNS])
						nxt[v] = 1'b1;
				end
			end
			cur = nxt;
		end
		return cur;
	endfunction

	// Any reached vertex in the right column
	function automatic logic right_reached(input logic [NV-1:0] seen_i);
		logic r;
		r = 1'b0;
		for (int y = 0; y < GRID_ROWS; y++) begin
			r = r | seen_i[y*GRID_COLUMNS+GRID_COLUMNS-1];
		end
		return r;
	endfunction

	logic [NUM_STAGES-1:0]   vld_s;
	logic [NV-1:0]           seen_s [NUM_STAGES];
	logic [NB_USE-1:0]       mask_s [NUM_STAGES];
	logic [NV-1:0]           seen_nxt [NUM_STAGES];
	logic [NUM_STAGES:0]     rdy;
	logic                    out_vld_q;
	logic                    crossed_q;

	// Ready chain: a stage loads when empty or when its content moves on
	always_comb begin
		rdy[NUM_STAGES] = !out_vld_q || m_tready;
		for (int i = NUM_STAGES - 1; i >= 0; i--) begin
			rdy[i] = !vld_s[i] || rdy[i+1];
		end
	end
	assign s_tready = rdy[0];

	// Relaxation inputs for each stage
	always_comb begin
		seen_nxt[0] = relax(left_column(), s_tdata[NB_USE-1:0]);
		for (int i = 1; i < NUM_STAGES; i++) begin
			seen_nxt[i] = relax(seen_s[i-1], mask_s[i-1]);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy[0])
				vld_s[0] <= s_tvalid;
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (rdy[i])
					vld_s[i] <= vld_s[i-1];
			end
			if (rdy[NUM_STAGES])
				out_vld_q <= vld_s[NUM_STAGES-1];
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			seen_s[0] <= seen_nxt[0];
			mask_s[0] <= s_tdata[NB_USE-1:0];
		end
		for (int i = 1; i < NUM_STAGES; i++) begin
			if (rdy[i]) begin
				seen_s[i] <= seen_nxt[i];
				mask_s[i] <= mask_s[i-1];
			end
		end
		if (rdy[NUM_STAGES])
			crossed_q <= right_reached(seen_s[NUM_STAGES-1]);
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, crossed_q};

	// Checks
	`GBCC_ASSERT_SAME(a_ready_when_drained, (!m_tvalid || m_tready), s_tready, "input stalled")
	`GBCC_ASSERT_NEXT(a_enter_first_stage, (s_tvalid && s_tready), vld_s[0], "request lost")
	`GBCC_ASSERT_NEXT(a_reach_output, vld_s[NUM_STAGES-1] && rdy[NUM_STAGES], m_tvalid, "no result")

endmodule
